>>> hdl/brct_pkg.sv
package brct_pkg;

  localparam int MAX_RANGES_DEF = 32;
  localparam int ADDR_BITS_DEF  = 48;

  localparam int FIELD_W  = 48;
  localparam int SUM_W    = 49;
  localparam int CNT_W    = 6;
  localparam int LOCK_W   = 16;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [2:0] {
    REQ_ADD    = 3'd0,
    REQ_CHECK  = 3'd1,
    REQ_CLEAR  = 3'd2,
    REQ_LOCK   = 3'd3,
    REQ_UNLOCK = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_FULL     = 2'd1,
    ERR_OVERFLOW = 2'd2,
    ERR_UNLOCK   = 2'd3
  } err_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL_SIZE = 2'd0,
    CFG_INIT_LOCK  = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic fin;
    logic resp;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
  } status_t;

endpackage

>>> hdl/brct_ram.sv
module brct_ram #(
  parameter int W = 8,
  parameter int D = 32
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata_r
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

>>> hdl/brct_ctrl.sv
module brct_ctrl
  import brct_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = status.need_scan ? S_SCAN : S_FIN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.resp      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hdl/brct_dp.sv
module brct_dp
  import brct_pkg::*;
#(
  parameter int MAX_RANGES = MAX_RANGES_DEF,
  parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic [2:0]           in_req_type,
  input  logic [FIELD_W-1:0]   in_offset,
  input  logic [FIELD_W-1:0]   in_length,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_data,
  output logic                 out_range_found,
  output logic                 out_complete,
  output logic [SUM_W-1:0]     out_covered_bytes,
  output logic [CNT_W-1:0]     out_range_count,
  output logic [1:0]           out_error_code
);

  localparam int AW = ((ADDR_BITS > SUM_W) ? ADDR_BITS : SUM_W) + 1;
  localparam int CW = $clog2(MAX_RANGES + 2);
  localparam int IW = $clog2(MAX_RANGES);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RANGES);

  // table and counters
  logic              bank_r;
  logic [CW-1:0]     n_r;
  logic [SUM_W-1:0]  sum_r;
  logic [LOCK_W-1:0] lock_r;
  logic [FIELD_W-1:0] tsize_r;
  logic [AW-1:0]     f0_r, l0_r;

  // request
  logic [2:0]    op_r;
  logic          scan_r;
  logic [1:0]    err_r;
  logic          found_r;

  // scan
  logic [CW-1:0]    ridx_r, pidx_r, oidx_r, k_r;
  logic             pv_r, placed_r;
  logic [AW-1:0]    lo_r, hi_r, t0f_r, t0l_r;
  logic [SUM_W-1:0] removed_r;

  logic [AW-1:0] hi_in, e1_in;
  logic          ovf, len_zero;

  logic [2*AW-1:0] rd0, rd1, rd, wdata;
  logic [AW-1:0]   ef, el;
  logic [IW-1:0]   raddr, waddr;
  logic [CW-1:0]   widx;
  logic            we, stall, err_full;

  assign len_zero = (in_length == '0);
  assign hi_in    = AW'(in_offset) + AW'(in_length) - AW'(1);
  assign ovf      = (hi_in >> ADDR_BITS) != '0;
  assign e1_in    = len_zero ? AW'(in_offset) : hi_in;

  assign status.need_scan = (in_req_type == REQ_CHECK) ||
                            ((in_req_type == REQ_ADD) && !len_zero && !ovf);
  assign status.scan_done = !pv_r && (ridx_r >= n_r);

  assign rd = bank_r ? rd1 : rd0;
  assign ef = rd[2*AW-1:AW];
  assign el = rd[AW-1:0];

  assign err_full = (k_r == '0) && (n_r == MAX_CNT);

  // scan step: copy, merge or emit merged range; at fin, write the merged range if not yet placed
  always_comb begin
    stall = 1'b0;
    we    = 1'b0;
    wdata = {ef, el};
    if (cmd.scan && pv_r && op_r == REQ_ADD) begin
      if (placed_r || ((el + AW'(1)) < lo_r)) begin
        we = 1'b1;
      end else if (ef <= hi_r + AW'(1)) begin
        we = 1'b0;
      end else begin
        we    = 1'b1;
        wdata = {lo_r, hi_r};
        stall = 1'b1;
      end
    end else if (cmd.fin && scan_r && op_r == REQ_ADD && !placed_r && !err_full) begin
      we    = 1'b1;
      wdata = {lo_r, hi_r};
    end
  end

  assign widx  = oidx_r;
  assign waddr = widx[IW-1:0];
  assign raddr = stall ? pidx_r[IW-1:0] : ridx_r[IW-1:0];

  brct_ram #(.W(2*AW), .D(MAX_RANGES)) u_ram0 (
    .clk(clk), .we(we && bank_r && (widx < MAX_CNT)), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata_r(rd0)
  );

  brct_ram #(.W(2*AW), .D(MAX_RANGES)) u_ram1 (
    .clk(clk), .we(we && !bank_r && (widx < MAX_CNT)), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata_r(rd1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r      <= 1'b0;
      n_r         <= '0;
      sum_r       <= '0;
      lock_r      <= '0;
      tsize_r     <= '0;
      pv_r        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_TOTAL_SIZE: tsize_r <= cfg_data;
          CFG_INIT_LOCK: begin
            lock_r      <= cfg_data[LOCK_W-1:0];
          end
          default: ;
        endcase
      end

      if (cmd.load) begin
        op_r      <= in_req_type;
        scan_r    <= status.need_scan;
        lo_r      <= AW'(in_offset);
        hi_r      <= (in_req_type == REQ_CHECK) ? e1_in : hi_in;
        err_r     <= (in_req_type == REQ_ADD && !len_zero && ovf) ? ERR_OVERFLOW : ERR_OK;
        found_r   <= 1'b0;
        ridx_r    <= '0;
        pidx_r    <= '0;
        oidx_r    <= '0;
        k_r       <= '0;
        pv_r      <= 1'b0;
        placed_r  <= 1'b0;
        removed_r <= '0;
      end

      if (cmd.scan) begin
        if (!stall) begin
          pidx_r <= ridx_r;
          pv_r   <= ridx_r < n_r;
          if (ridx_r < n_r) begin
            ridx_r <= ridx_r + CW'(1);
          end
        end
        if (pv_r && op_r == REQ_CHECK) begin
          if ((ef <= lo_r && lo_r <= el) || (ef <= hi_r && hi_r <= el)) begin
            found_r <= 1'b1;
          end
        end
        if (pv_r && op_r == REQ_ADD && !we) begin
          lo_r      <= (ef < lo_r) ? ef : lo_r;
          hi_r      <= (el > hi_r) ? el : hi_r;
          removed_r <= removed_r + SUM_W'(el - ef + AW'(1));
          k_r       <= k_r + CW'(1);
        end
        if (we) begin
          oidx_r <= oidx_r + CW'(1);
          if (oidx_r == '0) begin
            t0f_r <= wdata[2*AW-1:AW];
            t0l_r <= wdata[AW-1:0];
          end
        end
        if (stall) begin
          placed_r <= 1'b1;
        end
      end

      if (cmd.fin) begin
        case (op_r)
          REQ_ADD: begin
            if (scan_r) begin
              if (err_full) begin
                err_r <= ERR_FULL;
              end else begin
                bank_r <= !bank_r;
                n_r    <= oidx_r + (placed_r ? CW'(0) : CW'(1));
                sum_r  <= sum_r - removed_r + SUM_W'(hi_r - lo_r + AW'(1));
                if (!placed_r && oidx_r == '0) begin
                  f0_r <= lo_r;
                  l0_r <= hi_r;
                end else begin
                  f0_r <= t0f_r;
                  l0_r <= t0l_r;
                end
              end
            end
          end
          REQ_CLEAR: begin
            n_r   <= '0;
            sum_r <= '0;
          end
          REQ_LOCK: begin
            if (lock_r != '1) begin
              lock_r <= lock_r + LOCK_W'(1);
            end
          end
          REQ_UNLOCK: begin
            if (lock_r == '0) begin
              err_r <= ERR_UNLOCK;
            end else begin
              lock_r <= lock_r - LOCK_W'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      out_range_found   <= found_r && (op_r == REQ_CHECK);
      out_complete      <= (lock_r <= LOCK_W'(1)) &&
                           ((tsize_r == '0) ||
                            ((n_r == CW'(1)) && (f0_r == '0) &&
                             ((l0_r + AW'(1)) >= AW'(tsize_r))));
      out_covered_bytes <= sum_r;
      out_range_count   <= CNT_W'(n_r);
      out_error_code    <= err_r;
    end
  end

endmodule

>>> hdl/byte_range_coverage_tracker.sv
// Byte range coverage tracker: keeps a sorted table of disjoint received byte
// ranges, merges added ranges, answers end-point checks, and reports coverage,
// range count, completeness and error per request (one result per request).
// An add or check that scans the table walks it one table entry per cycle
// through a registered-read RAM, pausing while the merged range is emitted
// ahead of a later entry, then finishes and presents its result. Clear, lock,
// unlock, unknown requests and adds that are empty or run past the address
// space skip the scan. The next request is accepted in the cycle after the
// result is loaded. Adds that scan rewrite the table into a second RAM bank
// that then becomes current unless the table is full. A new request is taken
// while the previous result still waits at the output.
module byte_range_coverage_tracker
  import brct_pkg::*;
#(
  parameter int MAX_RANGES = MAX_RANGES_DEF,
  parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_req_type,
  input  logic [FIELD_W-1:0]   in_offset,
  input  logic [FIELD_W-1:0]   in_length,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_range_found,
  output logic                 out_complete,
  output logic [SUM_W-1:0]     out_covered_bytes,
  output logic [CNT_W-1:0]     out_range_count,
  output logic [1:0]           out_error_code,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  brct_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .cmd(cmd)
  );

  brct_dp #(.MAX_RANGES(MAX_RANGES), .ADDR_BITS(ADDR_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
    .in_req_type(in_req_type), .in_offset(in_offset), .in_length(in_length),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_range_found(out_range_found), .out_complete(out_complete),
    .out_covered_bytes(out_covered_bytes), .out_range_count(out_range_count),
    .out_error_code(out_error_code)
  );

endmodule

>>> hdl/brct_chk.sv
module brct_chk
  import brct_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_range_found,
  input logic [SUM_W-1:0] out_covered_bytes,
  input logic [CNT_W-1:0] out_range_count,
  input logic [1:0]       out_error_code
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("in_valid dropped before accept");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_covered_bytes))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_found |-> out_error_code == ERR_OK)
    else $error("range found with an error");

  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_count == '0 |-> out_covered_bytes == '0)
    else $error("bytes covered with no ranges");

endmodule

bind byte_range_coverage_tracker brct_chk u_brct_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_range_found(out_range_found), .out_covered_bytes(out_covered_bytes),
  .out_range_count(out_range_count), .out_error_code(out_error_code)
);

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import brct_pkg::*;

  localparam logic [2:0] REQ_RSVD_FIRST = 3'd5;
  localparam logic [2:0] REQ_RSVD_MID   = 3'd6;
  localparam logic [2:0] REQ_RSVD_LAST  = 3'd7;
  localparam logic [1:0] CFG_UNUSED     = 2'd2;
  localparam logic [63:0] ADDR_MASK     = 64'hFFFF_FFFF_FFFF;
  localparam int TABLE_DEPTH            = 32;
  localparam int STALL_LIMIT            = 5000;
  localparam int HOLD_CYCLES            = 400;

  typedef struct packed {
    logic             found;
    logic             complete;
    logic [SUM_W-1:0] covered;
    logic [CNT_W-1:0] count;
    logic [1:0]       err;
  } cov_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [2:0]           in_req_type;
  logic [FIELD_W-1:0]   in_offset;
  logic [FIELD_W-1:0]   in_length;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_range_found;
  logic                 out_complete;
  logic [SUM_W-1:0]     out_covered_bytes;
  logic [CNT_W-1:0]     out_range_count;
  logic [1:0]           out_error_code;
  logic                 cfg_valid;
  logic                 cfg_ready;
  cfg_reg_t             cfg_index;
  logic [FIELD_W-1:0]   cfg_data;

  logic [63:0] span_first [TABLE_DEPTH];
  logic [63:0] span_last  [TABLE_DEPTH];
  int          span_count;
  logic [63:0] bytes_held;
  logic [63:0] lock_level;
  logic [63:0] object_size;
  logic [63:0] lock_preset;

  cov_result_t pending_results[$];
  int          fail_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_req;
  int          hold_left;
  int          quiet_cycles;

  byte_range_coverage_tracker dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[47:0];
  endfunction

  function automatic logic object_complete();
    if (lock_level > 1) return 1'b0;
    if (object_size == 0) return 1'b1;
    if (span_count != 1) return 1'b0;
    if (span_first[0] != 0) return 1'b0;
    return (span_last[0] - span_first[0] + 1) >= object_size;
  endfunction

  function automatic logic [1:0] merge_range(logic [63:0] off, logic [63:0] len);
    logic [63:0] lo, hi, removed;
    int i, j, k, t;
    if (len == 0) return ERR_OK;
    lo = off;
    hi = off + len - 1;
    if (hi > ADDR_MASK) return ERR_OVERFLOW;
    removed = 0;
    i = 0;
    while (i < span_count && span_last[i] + 1 < lo) i++;
    j = i;
    while (j < span_count && span_first[j] <= hi + 1) begin
      if (span_first[j] < lo) lo = span_first[j];
      if (span_last[j] > hi) hi = span_last[j];
      removed += span_last[j] - span_first[j] + 1;
      j++;
    end
    k = j - i;
    if (k == 0) begin
      if (span_count >= TABLE_DEPTH) return ERR_FULL;
      for (t = span_count; t > i; t--) begin
        span_first[t] = span_first[t-1];
        span_last[t] = span_last[t-1];
      end
    end else if (k > 1) begin
      for (t = j; t < span_count; t++) begin
        span_first[t-k+1] = span_first[t];
        span_last[t-k+1] = span_last[t];
      end
    end
    span_first[i] = lo;
    span_last[i] = hi;
    span_count = span_count - k + 1;
    bytes_held = bytes_held - removed + (hi - lo + 1);
    return ERR_OK;
  endfunction

  function automatic logic probe_range(logic [63:0] off, logic [63:0] len);
    logic [63:0] e1;
    e1 = (len > 0) ? off + len - 1 : off;
    for (int i = 0; i < span_count; i++) begin
      if ((span_first[i] <= off && off <= span_last[i]) ||
          (span_first[i] <= e1 && e1 <= span_last[i]))
        return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic cov_result_t predict_coverage(logic [2:0] req, logic [47:0] off,
                                                   logic [47:0] len);
    cov_result_t r;
    r = '0;
    case (req)
      REQ_ADD: r.err = merge_range(64'(off), 64'(len));
      REQ_CHECK: r.found = probe_range(64'(off), 64'(len));
      REQ_CLEAR: begin
        span_count = 0;
        bytes_held = 0;
      end
      REQ_LOCK: if (lock_level < 64'hFFFF) lock_level++;
      REQ_UNLOCK: begin
        if (lock_level == 0) r.err = ERR_UNLOCK;
        else lock_level--;
      end
      default: ;
    endcase
    r.complete = object_complete();
    r.covered = bytes_held[SUM_W-1:0];
    r.count = span_count[CNT_W-1:0];
    return r;
  endfunction

  task automatic send_req(logic [2:0] req, logic [47:0] off, logic [47:0] len);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_offset <= off;
    in_length <= len;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_coverage(req, off, len));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [47:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= cfg_reg_t'(idx);
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_TOTAL_SIZE) object_size = 64'(value);
    else if (idx == CFG_INIT_LOCK) begin
      lock_preset = 64'(value[15:0]);
      lock_level = lock_preset;
    end
    @(posedge clk);
  endtask

  task automatic test_special_cases();
    write_reg(CFG_TOTAL_SIZE, 48'd0);
    write_reg(CFG_INIT_LOCK, 16'd0);
    write_reg(CFG_UNUSED, '1);
    send_req(REQ_ADD, 48'd100, 48'd0);
    send_req(REQ_ADD, '1, 48'd2);
    send_req(REQ_ADD, '1, 48'd1);
    send_req(REQ_ADD, 48'd0, '1);
    send_req(REQ_ADD, 48'd1, '1);
    send_req(REQ_CLEAR, '1, '1);
    send_req(REQ_ADD, 48'd10, 48'd10);
    send_req(REQ_ADD, 48'd12, 48'd3);
    send_req(REQ_ADD, 48'd20, 48'd5);
    send_req(REQ_ADD, 48'd0, 48'd10);
    send_req(REQ_ADD, 48'd40, 48'd5);
    send_req(REQ_ADD, 48'd30, 48'd20);
    send_req(REQ_CHECK, 48'd5, 48'd0);
    send_req(REQ_CHECK, 48'd60, 48'd0);
    send_req(REQ_CHECK, '1, '1);
    send_req(REQ_CHECK, 48'd26, 48'd3);
    send_req(REQ_UNLOCK, 48'd0, 48'd0);
    send_req(REQ_LOCK, 48'd0, 48'd0);
    send_req(REQ_LOCK, 48'd0, 48'd0);
    send_req(REQ_UNLOCK, 48'd0, 48'd0);
    send_req(REQ_RSVD_FIRST, 48'd1, 48'd1);
    send_req(REQ_RSVD_LAST, '1, '1);
    send_req(REQ_RSVD_MID, 48'd0, 48'd0);
    write_reg(CFG_INIT_LOCK, 16'hFFFF);
    send_req(REQ_LOCK, 48'd0, 48'd0);
    send_req(REQ_UNLOCK, 48'd0, 48'd0);
  endtask

  task automatic test_table_full();
    write_reg(CFG_INIT_LOCK, 16'd1);
    write_reg(CFG_TOTAL_SIZE, 48'd64);
    send_req(REQ_CLEAR, 48'd0, 48'd0);
    send_req(REQ_ADD, 48'd0, 48'd64);
    for (int i = 1; i <= TABLE_DEPTH; i++) send_req(REQ_ADD, 48'(i * 100), 48'd10);
    send_req(REQ_ADD, 48'd5000, 48'd1);
    send_req(REQ_ADD, 48'd105, 48'd2);
    send_req(REQ_ADD, 48'd110, 48'd90);
    send_req(REQ_ADD, 48'd5000, 48'd1);
    send_req(REQ_CLEAR, 48'd0, 48'd0);
  endtask

  task automatic random_burst(int items, int span);
    logic [2:0] req;
    int pick;
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(99);
      if (pick < 60) send_req(REQ_ADD, 48'($urandom_range(span)), 48'($urandom_range(24, 1)));
      else if (pick < 65) send_req(REQ_ADD, rand48(), rand48() >> $urandom_range(47));
      else if (pick < 80) send_req(REQ_CHECK, 48'($urandom_range(span)),
                                   48'($urandom_range(8)));
      else if (pick < 83) send_req(REQ_CHECK, rand48(), rand48());
      else if (pick < 86) send_req(REQ_CLEAR, rand48(), rand48());
      else if (pick < 92) send_req(REQ_LOCK, rand48(), rand48());
      else if (pick < 98) send_req(REQ_UNLOCK, rand48(), rand48());
      else begin
        req = 3'($urandom_range(REQ_RSVD_LAST, REQ_RSVD_FIRST));
        send_req(req, rand48(), rand48());
      end
    end
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 15;
    recv_idle_pct = 50;
    write_reg(CFG_TOTAL_SIZE, 48'd128);
    write_reg(CFG_INIT_LOCK, 16'd1);
    random_burst(165, 120);
    send_idle_pct = 50;
    recv_idle_pct = 15;
    write_reg(CFG_TOTAL_SIZE, '1);
    write_reg(CFG_INIT_LOCK, 16'd0);
    random_burst(165, 600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_TOTAL_SIZE, 48'd300);
    write_reg(CFG_INIT_LOCK, 16'd2);
    random_burst(165, 300);
  endtask

  task automatic test_output_backpressure();
    write_reg(CFG_TOTAL_SIZE, 48'd0);
    hold_req = 1'b1;
    random_burst(40, 200);
  endtask

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cov_result_t exp;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat", $time);
        fail_count++;
      end else begin
        exp = pending_results.pop_front();
        if (out_range_found !== exp.found) begin
          $display("%0t: range_found exp %0d got %0d", $time, exp.found, out_range_found);
          fail_count++;
        end
        if (out_complete !== exp.complete) begin
          $display("%0t: complete exp %0d got %0d", $time, exp.complete, out_complete);
          fail_count++;
        end
        if (out_covered_bytes !== exp.covered) begin
          $display("%0t: covered_bytes exp %0d got %0d", $time, exp.covered,
                   out_covered_bytes);
          fail_count++;
        end
        if (out_range_count !== exp.count) begin
          $display("%0t: range_count exp %0d got %0d", $time, exp.count, out_range_count);
          fail_count++;
        end
        if (out_error_code !== exp.err) begin
          $display("%0t: error_code exp %0d got %0d", $time, exp.err, out_error_code);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = '0;
    in_offset = '0;
    in_length = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_TOTAL_SIZE;
    cfg_data = '0;
    span_count = 0;
    bytes_held = 0;
    object_size = 0;
    lock_preset = 0;
    lock_level = 0;
    fail_count = 0;
    send_idle_pct = 15;
    recv_idle_pct = 50;
    hold_req = 1'b0;
    hold_left = 0;
    quiet_cycles = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_cases();
    test_table_full();
    test_output_backpressure();
    test_random_traffic();
    drain();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
